// ===== src/stepper_microstep_position_controller_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Stepper controller assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STEPPER_MICROSTEP_POSITION_CONTROLLER_UNIT_MACROS_SVH
`define STEPPER_MICROSTEP_POSITION_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication.
`define STMPC_ASSERT_IMPL(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication.
`define STMPC_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== src/stmpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper controller package
// Shared codes, word types and the target clamp used by the controller.
// ----------------------------------------------------------------------------
package stmpc_pkg;

  localparam logic [1:0] REQ_PWM    = 2'd0;
  localparam logic [1:0] REQ_TIMER  = 2'd1;
  localparam logic [1:0] REQ_TARGET = 2'd2;

  localparam logic [1:0] MODE_ABS = 2'd0;
  localparam logic [1:0] MODE_CW  = 2'd1;
  localparam logic [1:0] MODE_CCW = 2'd2;

  localparam logic [1:0] DIR_CCW  = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_STOP = 2'd2;

  localparam logic [1:0] DUTY_NONE = 2'd0;
  localparam logic [1:0] DUTY_FULL = 2'd1;
  localparam logic [1:0] DUTY_LOW  = 2'd2;

  localparam logic [2:0] CFG_MAX_LIMIT   = 3'd0;
  localparam logic [2:0] CFG_MIN_LIMIT   = 3'd1;
  localparam logic [2:0] CFG_MICRO_RATIO = 3'd2;
  localparam logic [2:0] CFG_SLOW_RATIO  = 3'd3;
  localparam logic [2:0] CFG_HOLD_DELAY  = 3'd4;

  localparam logic [15:0] POS_MAX         = 16'hFFFF;
  localparam logic [5:0]  MICROS_PER_STEP = 6'd32;

  typedef struct packed {
    logic [15:0] max_limit;
    logic [15:0] min_limit;
    logic [7:0]  micro_ratio;
    logic [7:0]  slow_micro_ratio;
    logic [15:0] hold_delay;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  move_mode;
    logic [15:0] move_value;
    logic        slow_mode;
  } req_t;

  typedef struct packed {
    logic [6:0]  phase_index;
    logic [1:0]  duty_update;
    logic [15:0] position;
    logic [15:0] target;
    logic [1:0]  motion;
  } res_t;

  function automatic logic [15:0] clamp_target(input logic [15:0] t,
                                               input logic [15:0] hi,
                                               input logic [15:0] lo);
    logic [15:0] r;
    r = t;
    if (r >= hi) r = hi;
    if (r <= lo) r = lo;
    return r;
  endfunction

endpackage

// ===== src/stmpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Stepper controller configuration registers
// Holds the limits, divider ratios and hold delay written over the cfg channel.
// ----------------------------------------------------------------------------
module stmpc_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [2:0]       wr_index,
  input  logic [31:0]      wr_data,
  output stmpc_pkg::cfg_t  cfg
);
  import stmpc_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_limit        <= 16'd65535;
      regs.min_limit        <= 16'd0;
      regs.micro_ratio      <= 8'd4;
      regs.slow_micro_ratio <= 8'd16;
      regs.hold_delay       <= 16'd40000;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_MAX_LIMIT:   regs.max_limit        <= wr_data[15:0];
        CFG_MIN_LIMIT:   regs.min_limit        <= wr_data[15:0];
        CFG_MICRO_RATIO: regs.micro_ratio      <= wr_data[7:0];
        CFG_SLOW_RATIO:  regs.slow_micro_ratio <= wr_data[7:0];
        CFG_HOLD_DELAY:  regs.hold_delay       <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== src/stmpc_core.sv =====
// ----------------------------------------------------------------------------
// Stepper controller core
// Motor state registers and the combinational update for one request word.
// ----------------------------------------------------------------------------
module stmpc_core #(
  parameter logic [15:0] HOME_POS = 16'd0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  stmpc_pkg::cfg_t  cfg,
  input  stmpc_pkg::req_t  req,
  output stmpc_pkg::res_t  res
);
  import stmpc_pkg::*;

  logic [15:0] cur_position, cur_position_next;
  logic [15:0] tgt_position, tgt_position_next;
  logic [1:0]  motion_dir, motion_dir_next;
  logic [6:0]  phase, phase_next;
  logic [7:0]  tick_divider, tick_divider_next;
  logic [4:0]  micro_in_step, micro_in_step_next;
  logic [15:0] stopped_ticks, stopped_ticks_next;
  logic [1:0]  duty;

  logic [7:0]  ratio;
  logic [7:0]  div_inc;
  logic [5:0]  micro_inc;
  logic [16:0] stop_inc;
  logic [16:0] add_sum;
  logic [15:0] raw_target;
  logic [15:0] lim_target;

  always_comb begin
    cur_position_next    = cur_position;
    tgt_position_next    = tgt_position;
    motion_dir_next      = motion_dir;
    phase_next           = phase;
    tick_divider_next    = tick_divider;
    micro_in_step_next   = micro_in_step;
    stopped_ticks_next   = stopped_ticks;
    duty                 = DUTY_NONE;

    ratio     = req.slow_mode ? cfg.slow_micro_ratio : cfg.micro_ratio;
    div_inc   = tick_divider + 8'd1;
    micro_inc = {1'b0, micro_in_step} + 6'd1;
    stop_inc  = {1'b0, stopped_ticks} + 17'd1;
    add_sum   = {1'b0, tgt_position} + {1'b0, req.move_value};

    case (req.move_mode)
      MODE_ABS: raw_target = req.move_value;
      MODE_CW:  raw_target = add_sum[16] ? POS_MAX : add_sum[15:0];
      MODE_CCW: raw_target = (tgt_position >= req.move_value) ?
                             tgt_position - req.move_value : 16'd0;
      default:  raw_target = tgt_position;
    endcase

    lim_target = clamp_target((req.req_type == REQ_TARGET) ? raw_target : tgt_position,
                              cfg.max_limit, cfg.min_limit);

    unique case (req.req_type)
      REQ_PWM: begin
        if (motion_dir != DIR_STOP) begin
          stopped_ticks_next = 16'd0;
          if (div_inc >= ratio) begin
            tick_divider_next = 8'd0;
            phase_next = (motion_dir == DIR_CW) ? phase - 7'd1 : phase + 7'd1;
            duty = DUTY_FULL;
            if (micro_inc >= MICROS_PER_STEP) begin
              micro_in_step_next = 5'd0;
              if (motion_dir == DIR_CW) begin
                if (cur_position != POS_MAX) cur_position_next = cur_position + 16'd1;
              end else begin
                if (cur_position != 16'd0) cur_position_next = cur_position - 16'd1;
              end
              motion_dir_next = DIR_STOP;
            end else begin
              micro_in_step_next = micro_inc[4:0];
            end
          end else begin
            tick_divider_next = div_inc;
          end
        end else if (stop_inc >= {1'b0, cfg.hold_delay}) begin
          stopped_ticks_next = cfg.hold_delay;
          duty = DUTY_LOW;
        end else begin
          stopped_ticks_next = stop_inc[15:0];
        end
      end
      REQ_TIMER: begin
        if (motion_dir == DIR_STOP) begin
          tgt_position_next = lim_target;
          if (cur_position > lim_target) motion_dir_next = DIR_CCW;
          else if (cur_position < lim_target) motion_dir_next = DIR_CW;
        end
      end
      REQ_TARGET: begin
        tgt_position_next = lim_target;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_position    <= HOME_POS;
      tgt_position    <= HOME_POS;
      motion_dir      <= DIR_STOP;
      phase           <= 7'd0;
      tick_divider    <= 8'd0;
      micro_in_step   <= 5'd0;
      stopped_ticks   <= 16'd0;
    end else if (en) begin
      cur_position    <= cur_position_next;
      tgt_position    <= tgt_position_next;
      motion_dir      <= motion_dir_next;
      phase           <= phase_next;
      tick_divider    <= tick_divider_next;
      micro_in_step   <= micro_in_step_next;
      stopped_ticks   <= stopped_ticks_next;
    end
  end

  always_comb begin
    res.phase_index = phase_next;
    res.duty_update = duty;
    res.position    = cur_position_next;
    res.target      = tgt_position_next;
    res.motion      = motion_dir_next;
  end

endmodule

// ===== src/stepper_microstep_position_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Stepper microstep position controller
// An accepted word waits in the input register until the result register is
// free, then its result is registered there. Throughput is one word per
// cycle while out_ready is high; the motor state update is combinational.
// Synchronous reset puts the motor at HOME_POS, stopped, with the
// default limits, ratios and hold delay, and empties both registers.
// ----------------------------------------------------------------------------
`include "stepper_microstep_position_controller_unit_macros.svh"

module stepper_microstep_position_controller_unit #(
  parameter logic [15:0] HOME_POS = 16'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [1:0]  move_mode,
  input  logic [15:0] move_value,
  input  logic        slow_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  phase_index,
  output logic [1:0]  duty_update,
  output logic [15:0] position,
  output logic [15:0] target,
  output logic [1:0]  motion
);
  import stmpc_pkg::*;

  cfg_t cfg;
  req_t held_req;
  res_t core_res;
  res_t held_res;
  logic in_full;
  logic proc;

  assign cfg_ready = 1'b1;
  assign proc      = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || proc;

  stmpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  stmpc_core #(
    .HOME_POS (HOME_POS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .en  (proc),
    .cfg (cfg),
    .req (held_req),
    .res (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_req.req_type   <= req_type;
      held_req.move_mode  <= move_mode;
      held_req.move_value <= move_value;
      held_req.slow_mode  <= slow_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      held_res <= core_res;
    end
  end

  assign phase_index = held_res.phase_index;
  assign duty_update = held_res.duty_update;
  assign position    = held_res.position;
  assign target      = held_res.target;
  assign motion      = held_res.motion;

  `STMPC_ASSERT_NEXT(a_proc_gives_result, proc, out_valid, "processed word gave no result")
  `STMPC_ASSERT_NEXT(a_held_word_kept, in_full && !proc, in_full, "held input word was dropped")
  `STMPC_ASSERT_IMPL(a_low_power_stopped, out_valid && (duty_update == DUTY_LOW),
                     motion == DIR_STOP, "low power table requested while moving")

endmodule
